// ----- sv/ctscan_pkg.sv -----
// Shared types and constants of the C-subset token scanner.
// Holds token kind codes, the result word struct and the keyword table.
// No dependencies.
`default_nettype none
package ctscan_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [4:0] K_NUM     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_KW0     = 5'd2;
  localparam logic [4:0] K_PLUS    = 5'd9;
  localparam logic [4:0] K_MINUS   = 5'd10;
  localparam logic [4:0] K_STAR    = 5'd11;
  localparam logic [4:0] K_SLASH   = 5'd12;
  localparam logic [4:0] K_PERCENT = 5'd13;
  localparam logic [4:0] K_ASSIGN  = 5'd14;
  localparam logic [4:0] K_EQ      = 5'd15;
  localparam logic [4:0] K_NE      = 5'd16;
  localparam logic [4:0] K_LT      = 5'd17;
  localparam logic [4:0] K_GT      = 5'd18;
  localparam logic [4:0] K_LE      = 5'd19;
  localparam logic [4:0] K_GE      = 5'd20;
  localparam logic [4:0] K_AND     = 5'd21;
  localparam logic [4:0] K_OR      = 5'd22;
  localparam logic [4:0] K_NOT     = 5'd23;
  localparam logic [4:0] K_LPAREN  = 5'd24;
  localparam logic [4:0] K_RPAREN  = 5'd25;
  localparam logic [4:0] K_LBRACE  = 5'd26;
  localparam logic [4:0] K_RBRACE  = 5'd27;
  localparam logic [4:0] K_SEMI    = 5'd28;
  localparam logic [4:0] K_COMMA   = 5'd29;
  localparam logic [4:0] K_EOF     = 5'd30;
  localparam logic [4:0] K_ERR     = 5'd31;

  localparam int NUM_KW = 7;

  // Keywords packed big-endian, first character in the highest used byte.
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0069_6E74,  // int
    64'h0000_0000_766F_6964,  // void
    64'h0000_0000_0000_6966,  // if
    64'h0000_0000_656C_7365,  // else
    64'h0000_0077_6869_6C65,  // while
    64'h0000_0000_0066_6F72,  // for
    64'h0000_7265_7475_726E   // return
  };
  localparam int KW_LEN [NUM_KW] = '{3, 4, 2, 4, 5, 3, 6};

  typedef struct packed {
    logic [4:0]  kind;
    logic [16:0] start;
    logic [16:0] len;
    logic [16:0] line;
    logic [16:0] col;
    logic [62:0] value;
    logic        ovf;
    logic        last;
  } tok_t;

  typedef struct packed {
    tok_t       tok0;
    tok_t       tok1;
    logic [1:0] count;
  } scan_res_t;

endpackage
`default_nettype wire

// ----- sv/ctscan_if.sv -----
// Channel interfaces of the token scanner: source bytes in, tokens out.
// Depends on nothing; each carries valid, ready and the word's fields.
`default_nettype none
interface ctscan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_source;
  modport source (output valid, text_byte, end_of_source, input ready);
  modport sink (input valid, text_byte, end_of_source, output ready);
endinterface

interface ctscan_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [16:0] token_offset;
  logic [16:0] token_length;
  logic [16:0] token_line;
  logic [16:0] token_column;
  logic [62:0] literal_value;
  logic        value_overflow;
  logic        last_of_run;
  modport source (output valid, token_kind, token_offset, token_length, token_line,
                  token_column, literal_value, value_overflow, last_of_run, input ready);
  modport sink (input valid, token_kind, token_offset, token_length, token_line,
                token_column, literal_value, value_overflow, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- sv/ctscan_core.sv -----
// Scanner state and per-byte next-state logic of the token scanner.
// Depends on ctscan_pkg; yields up to two tokens for each accepted word.
`default_nettype none
module ctscan_core
  import ctscan_pkg::*;
#(
  parameter int MAX_SOURCE_BYTES = 65536,
  parameter int KEYWORD_MAX_LEN  = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_source,
  output scan_res_t       res
);

  localparam int PW = $clog2(MAX_SOURCE_BYTES + 2);
  localparam int KB = 8 * KEYWORD_MAX_LEN;

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_OP, M_NUM, M_IDENT
  } mode_t;

  localparam logic [7:0] CH_SP = 8'h20, CH_TAB = 8'h09, CH_NL = 8'h0A, CH_CR = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F, CH_STAR = 8'h2A, CH_EQ = 8'h3D, CH_BANG = 8'h21;
  localparam logic [7:0] CH_LT = 8'h3C, CH_GT = 8'h3E, CH_AMP = 8'h26, CH_BAR = 8'h7C;
  localparam logic [7:0] CH_LPAR = 8'h28, CH_RPAR = 8'h29, CH_LBR = 8'h7B, CH_RBR = 8'h7D;
  localparam logic [7:0] CH_SEMI = 8'h3B, CH_COMMA = 8'h2C, CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D, CH_PCT = 8'h25;

  mode_t          mode_r, mode_nxt;
  logic [7:0]     pend_r, pend_nxt;
  logic [PW-1:0]  tstart_r, tstart_nxt, sline_r, sline_nxt, scol_r, scol_nxt;
  logic [PW-1:0]  run_r, run_nxt, pos_r, pos_nxt, line_r, line_nxt, col_r, col_nxt;
  logic [62:0]    acc_r, acc_nxt;
  logic           ovf_r, ovf_nxt, star_r, star_nxt;
  logic [KB-1:0]  kbuf_r, kbuf_nxt;

  function automatic logic [16:0] pos17(input logic [PW-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[16:0];
  endfunction

  function automatic logic [4:0] single_op(input logic [7:0] ch);
    case (ch)
      CH_EQ:   return K_ASSIGN;
      CH_BANG: return K_NOT;
      CH_LT:   return K_LT;
      CH_GT:   return K_GT;
      default: return K_ERR;
    endcase
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic        is_dig, is_alpha, fv, bv, emit_f, emit_b, step, do_begin, pair;
    logic [66:0] sum;
    logic [4:0]  ident_k, pair_k;
    tok_t        f, b, eof;

    c        = text_byte;
    is_dig   = (c >= 8'h30) && (c <= 8'h39);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
               || (c == 8'h5F);

    mode_nxt = mode_r;  pend_nxt = pend_r;  tstart_nxt = tstart_r;
    sline_nxt = sline_r; scol_nxt = scol_r; run_nxt = run_r;
    pos_nxt = pos_r;    line_nxt = line_r;  col_nxt = col_r;
    acc_nxt = acc_r;    ovf_nxt = ovf_r;    star_nxt = star_r;
    kbuf_nxt = kbuf_r;
    emit_f = 1'b0; emit_b = 1'b0; step = 1'b0; do_begin = 1'b0;

    ident_k = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if ((run_r == PW'(KW_LEN[k])) && (KW_LEN[k] <= KEYWORD_MAX_LEN)
          && (64'(kbuf_r) == KW_TEXT[k])) begin
        ident_k = K_KW0 + 5'(k);
      end
    end

    f       = '0;
    f.start = pos17(tstart_r);
    f.line  = pos17(sline_r);
    f.col   = pos17(scol_r);
    f.len   = 17'd1;
    fv      = 1'b1;
    case (mode_r)
      M_SLASH: f.kind = K_SLASH;
      M_OP:    f.kind = single_op(pend_r);
      M_NUM: begin
        f.kind  = K_NUM;
        f.len   = pos17(run_r);
        f.value = acc_r;
        f.ovf   = ovf_r;
      end
      M_IDENT: begin
        f.kind = ident_k;
        f.len  = pos17(run_r);
      end
      default: fv = 1'b0;
    endcase

    b       = '0;
    b.start = pos17(pos_r);
    b.line  = pos17(line_r);
    b.col   = pos17(col_r);
    b.len   = 17'd1;
    bv      = 1'b1;
    case (c)
      CH_LPAR:  b.kind = K_LPAREN;
      CH_RPAR:  b.kind = K_RPAREN;
      CH_LBR:   b.kind = K_LBRACE;
      CH_RBR:   b.kind = K_RBRACE;
      CH_SEMI:  b.kind = K_SEMI;
      CH_COMMA: b.kind = K_COMMA;
      CH_PLUS:  b.kind = K_PLUS;
      CH_MINUS: b.kind = K_MINUS;
      CH_STAR:  b.kind = K_STAR;
      CH_PCT:   b.kind = K_PERCENT;
      CH_SP, CH_TAB, CH_NL, CH_CR, CH_SLASH, CH_EQ, CH_BANG, CH_LT, CH_GT,
      CH_AMP, CH_BAR: bv = 1'b0;
      default: begin
        b.kind = K_ERR;
        bv     = !(is_dig || is_alpha);
      end
    endcase

    eof       = '0;
    eof.kind  = K_EOF;
    eof.start = pos17(pos_r);
    eof.line  = pos17(line_r);
    eof.col   = pos17(col_r);
    eof.len   = 17'd0;
    eof.last  = 1'b1;

    sum    = (67'(acc_r) << 3) + (67'(acc_r) << 1) + 67'(c[3:0]);
    pair   = 1'b0;
    pair_k = K_ERR;
    if (c == CH_EQ) begin
      pair = 1'b1;
      case (pend_r)
        CH_EQ:   pair_k = K_EQ;
        CH_BANG: pair_k = K_NE;
        CH_LT:   pair_k = K_LE;
        CH_GT:   pair_k = K_GE;
        default: pair = 1'b0;
      endcase
    end else if ((c == CH_AMP) && (pend_r == CH_AMP)) begin
      pair = 1'b1; pair_k = K_AND;
    end else if ((c == CH_BAR) && (pend_r == CH_BAR)) begin
      pair = 1'b1; pair_k = K_OR;
    end

    if (end_of_source) begin
      mode_nxt = M_IDLE;  pend_nxt = '0;  tstart_nxt = '0;
      sline_nxt = PW'(1); scol_nxt = '0;  run_nxt = '0;
      acc_nxt = '0;       ovf_nxt = 1'b0; kbuf_nxt = '0;
      pos_nxt = '0;       line_nxt = PW'(1); col_nxt = '0;
      star_nxt = 1'b0;
    end else if (pos_r < PW'(MAX_SOURCE_BYTES)) begin
      unique case (mode_r)
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = M_LINE; step = 1'b1;
          end else if (c == CH_STAR) begin
            mode_nxt = M_BLOCK; star_nxt = 1'b0; step = 1'b1;
          end else begin
            emit_f = 1'b1; do_begin = 1'b1;
          end
        end
        M_LINE: begin
          if (c == CH_NL) do_begin = 1'b1;
          else step = 1'b1;
        end
        M_BLOCK: begin
          if (star_r && (c == CH_SLASH)) begin
            mode_nxt = M_IDLE; star_nxt = 1'b0;
          end else begin
            star_nxt = (c == CH_STAR);
          end
          step = 1'b1;
        end
        M_OP: begin
          emit_f = 1'b1;
          if (pair) begin
            f.kind = pair_k; f.len = 17'd2; mode_nxt = M_IDLE; step = 1'b1;
          end else begin
            do_begin = 1'b1;
          end
        end
        M_NUM: begin
          if (is_dig) begin
            if (ovf_r || (sum[66:63] != 4'd0)) begin
              acc_nxt = '1; ovf_nxt = 1'b1;
            end else begin
              acc_nxt = sum[62:0];
            end
            run_nxt = run_r + PW'(1); step = 1'b1;
          end else begin
            emit_f = 1'b1; do_begin = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha || is_dig) begin
            if (run_r < PW'(KEYWORD_MAX_LEN)) kbuf_nxt = {kbuf_r[KB-9:0], c};
            run_nxt = run_r + PW'(1); step = 1'b1;
          end else begin
            emit_f = 1'b1; do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase
    end

    if (do_begin) begin
      tstart_nxt = pos_r; sline_nxt = line_r; scol_nxt = col_r;
      mode_nxt = M_IDLE;  emit_b = bv;        step = 1'b1;
      if (c == CH_SLASH) begin
        mode_nxt = M_SLASH;
      end else if ((c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT)
                   || (c == CH_AMP) || (c == CH_BAR)) begin
        mode_nxt = M_OP; pend_nxt = c;
      end else if (is_dig) begin
        mode_nxt = M_NUM; acc_nxt = 63'(c[3:0]); ovf_nxt = 1'b0; run_nxt = PW'(1);
      end else if (is_alpha) begin
        mode_nxt = M_IDENT; kbuf_nxt = KB'(c); run_nxt = PW'(1);
      end
    end

    if (step) begin
      pos_nxt = pos_r + PW'(1);
      if (c == CH_NL) begin
        line_nxt = line_r + PW'(1); col_nxt = '0;
      end else begin
        col_nxt = col_r + PW'(1);
      end
    end

    if (end_of_source) begin
      res.tok0  = fv ? f : eof;
      res.tok1  = eof;
      res.count = fv ? 2'd2 : 2'd1;
    end else begin
      res.tok0  = emit_f ? f : b;
      res.tok1  = b;
      res.count = 2'(emit_f) + 2'(emit_b);
      res.tok0.last = (res.count == 2'd1);
      res.tok1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;  pend_r <= '0;  tstart_r <= '0;
      sline_r <= PW'(1); scol_r <= '0;  run_r <= '0;
      acc_r <= '0;       ovf_r <= 1'b0; kbuf_r <= '0;
      pos_r <= '0;       line_r <= PW'(1); col_r <= '0;
      star_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;   pend_r <= pend_nxt;   tstart_r <= tstart_nxt;
      sline_r <= sline_nxt; scol_r <= scol_nxt;   run_r <= run_nxt;
      acc_r <= acc_nxt;     ovf_r <= ovf_nxt;     kbuf_r <= kbuf_nxt;
      pos_r <= pos_nxt;     line_r <= line_nxt;   col_r <= col_nxt;
      star_r <= star_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/c_subset_token_scanner_top.sv -----
// Top level of the C-subset token scanner: scanner core plus result queue.
// Depends on ctscan_pkg, ctscan_if and ctscan_core.
//
// Usage: source text enters on in_ch one byte per word; a word with
// end_of_source set closes the source, flushes any pending token and
// yields EOF, after which the block starts over at offset 0, line 1.
// Tokens leave on out_ch one per word; last_of_run marks the final token
// caused by an input word.
// Throughput: one input word per cycle while input ready is high. A word
// causes zero, one or two tokens, which enter a four-entry result queue in
// the cycle of acceptance; with an empty queue the first token is visible in
// the cycle after the word is accepted. The queue read port, one token per
// cycle while the receiver is ready, sets the sustained output rate.
// Input ready is high while the queue holds at most two tokens, so a word
// that yields two tokens always finds room. A stalled receiver stops
// intake once three or more tokens wait; words that yield no token are
// still taken until then.
// Synchronous reset returns the scanner to line 1, column 0 and empties
// the queue.
`default_nettype none
module c_subset_token_scanner_top
  import ctscan_pkg::*;
#(
  parameter int MAX_SOURCE_BYTES = 65536,
  parameter int KEYWORD_MAX_LEN  = 6
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ctscan_in_if.sink     in_ch,
  ctscan_out_if.source  out_ch
);

  localparam int AW = $clog2(FIFO_DEPTH);

  scan_res_t   res;
  tok_t        mem [FIFO_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;
  logic          accept, pop;
  tok_t          head;

  assign in_ch.ready = (cnt_r <= (AW+1)'(FIFO_DEPTH - 2));
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  ctscan_core #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_ch.text_byte),
    .end_of_source(in_ch.end_of_source),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (accept && (res.count != 2'd0)) mem[wptr_r] <= res.tok0;
    if (accept && (res.count == 2'd2)) mem[wptr_r + AW'(1)] <= res.tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (accept) wptr_r <= wptr_r + AW'(res.count);
      if (pop) rptr_r <= rptr_r + AW'(1);
      cnt_r <= cnt_r + (accept ? (AW+1)'(res.count) : '0) - (AW+1)'(pop);
    end
  end

  assign head                  = mem[rptr_r];
  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.token_kind     = head.kind;
  assign out_ch.token_offset   = head.start;
  assign out_ch.token_length   = head.len;
  assign out_ch.token_line     = head.line;
  assign out_ch.token_column   = head.col;
  assign out_ch.literal_value  = head.value;
  assign out_ch.value_overflow = head.ovf;
  assign out_ch.last_of_run    = head.last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(FIFO_DEPTH)) else $error("result queue overfilled");

  a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.end_of_source) |=> (cnt_r != '0))
    else $error("end word left no token queued");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r - rptr_r) == cnt_r[AW-1:0]) else $error("queue pointers and count disagree");

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench of the C-subset token scanner: drives source bytes, predicts tokens.
// Depends on ctscan_pkg, ctscan_if and c_subset_token_scanner_top.
`timescale 1ns / 1ps
module tb_top;
  import ctscan_pkg::*;

  localparam int SRC_LIMIT = 65536;
  localparam int KW_MAX = 6;
  localparam int WATCHDOG = 5000;
  localparam logic [62:0] SAT_VALUE = {63{1'b1}};

  typedef struct packed {
    logic [7:0] text_byte;
    logic       eos;
  } src_word_t;

  typedef enum logic [3:0] {
    SC_IDLE, SC_SLASH, SC_LINE, SC_BLOCK, SC_OP, SC_NUM, SC_IDENT
  } scan_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  ctscan_in_if in_ch();
  ctscan_out_if out_ch();

  c_subset_token_scanner_top DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  src_word_t pending_words[$];
  tok_t expected_tokens[$];

  scan_state_t sc_mode;
  logic [7:0] sc_pend;
  logic [16:0] sc_tstart, sc_sline, sc_scol, sc_run, sc_pos, sc_line, sc_col;
  logic [62:0] sc_acc;
  logic sc_ovf, sc_star;
  logic [47:0] sc_kwbuf;
  tok_t step_toks[$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_out = 1'b0;
  bit hold_in = 1'b0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void scan_reset();
    sc_mode = SC_IDLE; sc_pend = '0; sc_tstart = '0; sc_sline = 17'd1; sc_scol = '0;
    sc_run = '0; sc_acc = '0; sc_ovf = 1'b0; sc_kwbuf = '0; sc_pos = '0; sc_line = 17'd1;
    sc_col = '0; sc_star = 1'b0;
  endfunction

  function automatic void emit(logic [4:0] k, logic [16:0] s, logic [16:0] l,
                               logic [16:0] ln, logic [16:0] c, logic [62:0] v, logic o);
    tok_t t;
    t.kind = k; t.start = s; t.len = l; t.line = ln; t.col = c;
    t.value = v; t.ovf = o; t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void emit_here(logic [4:0] k, logic [16:0] l);
    emit(k, sc_tstart, l, sc_sline, sc_scol, '0, 1'b0);
  endfunction

  function automatic void advance(logic [7:0] c);
    sc_pos++;
    if (c == 8'h0A) begin
      sc_line++;
      sc_col = '0;
    end else begin
      sc_col++;
    end
  endfunction

  function automatic logic [4:0] name_kind();
    logic [63:0] kw [7];
    int kl [7];
    kw = '{64'h696E74, 64'h766F6964, 64'h6966, 64'h656C7365, 64'h7768696C65,
           64'h666F72, 64'h72657475726E};
    kl = '{3, 4, 2, 4, 5, 3, 6};
    for (int k = 0; k < 7; k++)
      if (17'(kl[k]) == sc_run && kl[k] <= KW_MAX && kw[k] == {16'h0, sc_kwbuf})
        return K_KW0 + 5'(k);
    return K_IDENT;
  endfunction

  function automatic logic [4:0] lone_op_kind(logic [7:0] c);
    case (c)
      "=": return K_ASSIGN;
      "!": return K_NOT;
      "<": return K_LT;
      ">": return K_GT;
      default: return K_ERR;
    endcase
  endfunction

  function automatic void flush_pending();
    case (sc_mode)
      SC_SLASH: emit_here(K_SLASH, 17'd1);
      SC_OP: emit_here(lone_op_kind(sc_pend), 17'd1);
      SC_NUM: emit(K_NUM, sc_tstart, sc_run, sc_sline, sc_scol, sc_acc, sc_ovf);
      SC_IDENT: emit_here(name_kind(), sc_run);
      default: ;
    endcase
    sc_mode = SC_IDLE;
  endfunction

  function automatic void start_token(logic [7:0] c);
    sc_tstart = sc_pos; sc_sline = sc_line; sc_scol = sc_col;
    case (c)
      " ", 8'h09, 8'h0A, 8'h0D: ;
      "/": sc_mode = SC_SLASH;
      "(": emit_here(K_LPAREN, 17'd1);
      ")": emit_here(K_RPAREN, 17'd1);
      "{": emit_here(K_LBRACE, 17'd1);
      "}": emit_here(K_RBRACE, 17'd1);
      ";": emit_here(K_SEMI, 17'd1);
      ",": emit_here(K_COMMA, 17'd1);
      "+": emit_here(K_PLUS, 17'd1);
      "-": emit_here(K_MINUS, 17'd1);
      "*": emit_here(K_STAR, 17'd1);
      "%": emit_here(K_PERCENT, 17'd1);
      "=", "!", "<", ">", "&", "|": begin
        sc_mode = SC_OP;
        sc_pend = c;
      end
      default: begin
        if (is_digit(c)) begin
          sc_mode = SC_NUM; sc_acc = 63'(c - 8'h30); sc_ovf = 1'b0; sc_run = 17'd1;
        end else if (is_alpha(c)) begin
          sc_mode = SC_IDENT; sc_kwbuf = 48'(c); sc_run = 17'd1;
        end else begin
          emit_here(K_ERR, 17'd1);
        end
      end
    endcase
    advance(c);
  endfunction

  function automatic void predict_tokens(src_word_t w);
    logic [7:0] c;
    logic [4:0] k;
    logic [62:0] d;
    bit pair;
    c = w.text_byte;
    step_toks.delete();
    if (w.eos) begin
      flush_pending();
      emit(K_EOF, sc_pos, 17'd0, sc_line, sc_col, '0, 1'b0);
      scan_reset();
    end else if (sc_pos < 17'(SRC_LIMIT)) begin
      case (sc_mode)
        SC_SLASH: begin
          if (c == "/") begin
            sc_mode = SC_LINE; advance(c);
          end else if (c == "*") begin
            sc_mode = SC_BLOCK; sc_star = 1'b0; advance(c);
          end else begin
            flush_pending(); start_token(c);
          end
        end
        SC_LINE: begin
          if (c == 8'h0A) begin
            sc_mode = SC_IDLE; start_token(c);
          end else begin
            advance(c);
          end
        end
        SC_BLOCK: begin
          if (sc_star && c == "/") begin
            sc_mode = SC_IDLE; sc_star = 1'b0;
          end else begin
            sc_star = (c == "*");
          end
          advance(c);
        end
        SC_OP: begin
          k = K_ERR;
          pair = 0;
          if (c == "=") begin
            pair = 1;
            if (sc_pend == "=") k = K_EQ;
            else if (sc_pend == "!") k = K_NE;
            else if (sc_pend == "<") k = K_LE;
            else if (sc_pend == ">") k = K_GE;
            else pair = 0;
          end else if (c == "&" && sc_pend == "&") begin
            pair = 1; k = K_AND;
          end else if (c == "|" && sc_pend == "|") begin
            pair = 1; k = K_OR;
          end
          if (pair) begin
            emit_here(k, 17'd2); sc_mode = SC_IDLE; advance(c);
          end else begin
            flush_pending(); start_token(c);
          end
        end
        SC_NUM: begin
          if (is_digit(c)) begin
            d = 63'(c - 8'h30);
            if (sc_ovf || sc_acc > (SAT_VALUE - d) / 63'd10) begin
              sc_acc = SAT_VALUE; sc_ovf = 1'b1;
            end else begin
              sc_acc = sc_acc * 63'd10 + d;
            end
            sc_run++; advance(c);
          end else begin
            flush_pending(); start_token(c);
          end
        end
        SC_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (sc_run < 17'(KW_MAX)) sc_kwbuf = {sc_kwbuf[39:0], c};
            sc_run++; advance(c);
          end else begin
            flush_pending(); start_token(c);
          end
        end
        default: begin
          sc_mode = SC_IDLE; start_token(c);
        end
      endcase
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  // Driver: one word at a time from the queue, with a random gap after each.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.text_byte <= '0;
      in_ch.end_of_source <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_tokens({in_ch.text_byte, in_ch.end_of_source});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0 || hold_in || pending_words.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          in_ch.valid <= 1'b1;
          {in_ch.text_byte, in_ch.end_of_source} <= pending_words.pop_front();
          in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        end
      end
    end
  end

  // Monitor: checks each accepted token against the oldest prediction.
  int out_gap = 0;
  always @(posedge clk) begin
    tok_t want, got;
    int g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.token_kind, out_ch.token_offset, out_ch.token_length,
                out_ch.token_line, out_ch.token_column, out_ch.literal_value,
                out_ch.value_overflow, out_ch.last_of_run};
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token word %h", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("token mismatch: expected %h, actual %h", want, got);
          end
        end
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        out_gap <= (g > 0) ? g - 1 : 0;
        out_ch.ready <= (g == 0) && !hold_out;
      end else if (hold_out) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pending_words.push_back({s[i], 1'b0});
  endtask

  task automatic add_end();
    pending_words.push_back({8'h00, 1'b1});
  endtask

  task automatic add_random_source(int n);
    string frags [24];
    frags = '{"int ", "void", "if", "else", "while", "for", "return", "x1_", "abcdefgh",
              "0", "98765", "==", "!=", "<=", ">=", "&&", "||", "= ", "!", "<",
              "/*a**/", "// c\n", "(){};,+-*/%", "\n\t\r "};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: pending_words.push_back({8'($urandom_range(0, 255)), 1'b0});
        1: pending_words.push_back({8'($urandom_range(128, 255)), 1'b0});
        2: pending_words.push_back({8'($urandom_range(32, 126)), 1'b0});
        default: add_text(frags[$urandom_range(0, 23)]);
      endcase
    end
    add_end();
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_ch.valid || expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    scan_reset();
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_source = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    add_text("int void if else while for return returns _Zz9 & | &&||");
    add_end();
    add_text("=<>!==!=<=>= 9223372036854775807 9223372036854775808 0/a/");
    add_end();
    pending_words.push_back({8'h00, 1'b0});
    pending_words.push_back({8'hFF, 1'b0});
    add_text("/*/ */x/* **/y// z\nq/* open");
    add_end();
    add_end();
    wait_drained();
    hold_out = 1'b1;
    for (int i = 0; i < 60; i++) add_text("; ");
    add_end();
    for (int i = 0; i < 400; i++) @(posedge clk);
    hold_out = 1'b0;
    wait_drained();
    hold_in = 1'b1;
    add_random_source(20);
    for (int i = 0; i < 30; i++) @(posedge clk);
    hold_in = 1'b0;
    for (int s = 0; s < 18; s++) add_random_source($urandom_range(5, 25));
    while (pending_words.size() != 0) @(posedge clk);
    wait_drained();
    for (int i = 0; i < 20; i++) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
